[design/olist_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types, codes and command/status structs for the ordered list store.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int DEF_CAPACITY = 16;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_DELETE  = 2'd1,
		MODE_REVERSE = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1,
		RD_HI,
		RD_POS
	} rd_sel_t;

	typedef enum logic {
		WA_IDX,
		WA_HI
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_VALUE,
		WD_RDATA,
		WD_TMP
	} wd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_RD,
		S_DEL_CMP,
		S_SH_CHK,
		S_SH_WR,
		S_REV_CHK,
		S_REV_RDHI,
		S_REV_WRLO,
		S_REV_WRHI,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wr_addr_sel;
		wd_sel_t wr_data_sel;
		logic    idx_ld_len;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_dec;
		logic    hi_ld;
		logic    hi_dec;
		logic    tmp_ld;
		logic    len_inc;
		logic    len_dec;
		logic    set_stat;
		status_t stat;
		logic    res_load;
	} olist_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  len_le1;
		logic  pos_ok;
		logic  idx_zero;
		logic  idx_eq_len;
		logic  idx_last;
		logic  idx_lt_hi;
		logic  match;
		logic  res_free;
	} olist_stat_t;

endpackage

[design/olist_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface olist_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] value;
	logic [3:0]         position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);
endinterface

interface olist_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic signed [31:0] read_value;

	modport source (output valid, output status, output entry_count, output read_value,
		input ready);
	modport sink (input valid, input status, input entry_count, input read_value,
		output ready);
endinterface

[design/ordered_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of 32-bit values with insert, delete, reverse and read.
// ----------------------------------------------------------------------------
// one command is in work at a time: the next is taken at the earliest in the cycle after
// the result is loaded. Each moved entry costs a read and then a write step; a waiting
// result stalls only the finish.
// arst_n empties the list and drops the pending result; entries are not cleared.
module ordered_list_store #(
	parameter int CAPACITY = olist_pkg::DEF_CAPACITY
) (
	input logic         clk,
	input logic         arst_n,
	olist_cmd_if.sink   cmd,
	olist_res_if.source res
);
	import olist_pkg::*;

	olist_cmd_t  cc;
	olist_stat_t st;
	logic        ready;

	assign cmd.ready = ready;

	olist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (ready),
		.st        (st),
		.cc        (cc)
	);

	olist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mode     (cmd.mode),
		.in_value    (cmd.value),
		.in_position (cmd.position),
		.cc          (cc),
		.st          (st),
		.res         (res)
	);

endmodule

[design/olist_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ctrl
// Sequencer that steps the datapath through insert, delete, reverse and read.
// ----------------------------------------------------------------------------
module olist_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  olist_pkg::olist_stat_t st,
	output olist_pkg::olist_cmd_t  cc
);
	import olist_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cc             = '0;
		cc.rd_sel      = RD_IDX;
		cc.wr_addr_sel = WA_IDX;
		cc.wr_data_sel = WD_VALUE;
		cc.stat        = ST_OK;
		cmd_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cc.load = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				case (st.mode)
					MODE_INSERT: begin
						if (st.full) begin
							cc.set_stat = 1'b1;
							cc.stat     = ST_FULL;
							state_d     = S_FINISH;
						end else begin
							cc.idx_ld_len = 1'b1;
							state_d       = S_INS_CHK;
						end
					end
					MODE_DELETE: begin
						cc.idx_clr = 1'b1;
						state_d    = S_DEL_RD;
					end
					MODE_REVERSE: begin
						if (st.len_le1) begin
							state_d = S_FINISH;
						end else begin
							cc.idx_clr = 1'b1;
							cc.hi_ld   = 1'b1;
							state_d    = S_REV_CHK;
						end
					end
					MODE_READ: begin
						if (st.pos_ok) begin
							cc.rd_en  = 1'b1;
							cc.rd_sel = RD_POS;
						end else begin
							cc.set_stat = 1'b1;
							cc.stat     = ST_RANGE;
						end
						state_d = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			// shift towards the tail, then write the new value at the head
			S_INS_CHK: begin
				if (st.idx_zero) begin
					cc.wr_en       = 1'b1;
					cc.wr_data_sel = WD_VALUE;
					cc.len_inc     = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cc.rd_en  = 1'b1;
					cc.rd_sel = RD_IDX_M1;
					state_d   = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cc.wr_en       = 1'b1;
				cc.wr_data_sel = WD_RDATA;
				cc.idx_dec     = 1'b1;
				state_d        = S_INS_CHK;
			end
			S_DEL_RD: begin
				if (st.idx_eq_len) begin
					cc.set_stat = 1'b1;
					cc.stat     = ST_NOT_FOUND;
					state_d     = S_FINISH;
				end else begin
					cc.rd_en  = 1'b1;
					cc.rd_sel = RD_IDX;
					state_d   = S_DEL_CMP;
				end
			end
			S_DEL_CMP: begin
				if (st.match) begin
					state_d = S_SH_CHK;
				end else begin
					cc.idx_inc = 1'b1;
					state_d    = S_DEL_RD;
				end
			end
			// close the gap left by the removed entry
			S_SH_CHK: begin
				if (st.idx_last) begin
					cc.len_dec = 1'b1;
					state_d    = S_FINISH;
				end else begin
					cc.rd_en  = 1'b1;
					cc.rd_sel = RD_IDX_P1;
					state_d   = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cc.wr_en       = 1'b1;
				cc.wr_data_sel = WD_RDATA;
				cc.idx_inc     = 1'b1;
				state_d        = S_SH_CHK;
			end
			S_REV_CHK: begin
				if (st.idx_lt_hi) begin
					cc.rd_en  = 1'b1;
					cc.rd_sel = RD_IDX;
					state_d   = S_REV_RDHI;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_REV_RDHI: begin
				cc.tmp_ld = 1'b1;
				cc.rd_en  = 1'b1;
				cc.rd_sel = RD_HI;
				state_d   = S_REV_WRLO;
			end
			S_REV_WRLO: begin
				cc.wr_en       = 1'b1;
				cc.wr_addr_sel = WA_IDX;
				cc.wr_data_sel = WD_RDATA;
				state_d        = S_REV_WRHI;
			end
			S_REV_WRHI: begin
				cc.wr_en       = 1'b1;
				cc.wr_addr_sel = WA_HI;
				cc.wr_data_sel = WD_TMP;
				cc.idx_inc     = 1'b1;
				cc.hi_dec      = 1'b1;
				state_d        = S_REV_CHK;
			end
			// wait here until the output register is free
			S_FINISH: begin
				if (st.res_free) begin
					cc.res_load = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[design/olist_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_dp
// Entry memory, length and index counters, and the result output register.
// ----------------------------------------------------------------------------
module olist_dp #(
	parameter int CAPACITY = olist_pkg::DEF_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             in_mode,
	input  logic [31:0]            in_value,
	input  logic [3:0]             in_position,
	input  olist_pkg::olist_cmd_t  cc,
	output olist_pkg::olist_stat_t st,
	olist_res_if.source            res
);
	import olist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 5) ? LW : 5;

	logic [31:0]   mem_q [CAPACITY];
	logic [31:0]   rdata_q, tmp_q, value_q;
	logic [3:0]    pos_q;
	mode_t         mode_q;
	status_t       stat_q;
	logic [LW-1:0] len_q, idx_q, hi_q;
	logic          out_valid_q;
	status_t       out_stat_q;
	logic [4:0]    out_count_q;
	logic [31:0]   out_value_q;

	logic [CW-1:0] pos_ext, len_ext;
	logic [LW-1:0] idx_m1, idx_p1, rd_addr_full, wr_addr_full;
	logic [LW:0]   idx_p1_wide;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wdata;

	assign pos_ext     = CW'(pos_q);
	assign len_ext     = CW'(len_q);
	assign idx_m1      = idx_q - LW'(1);
	assign idx_p1      = idx_q + LW'(1);
	assign idx_p1_wide = (LW + 1)'(idx_q) + (LW + 1)'(1);

	always_comb begin
		case (cc.rd_sel)
			RD_IDX:    rd_addr_full = idx_q;
			RD_IDX_M1: rd_addr_full = idx_m1;
			RD_IDX_P1: rd_addr_full = idx_p1;
			RD_HI:     rd_addr_full = hi_q;
			RD_POS:    rd_addr_full = pos_ext[LW-1:0];
			default:   rd_addr_full = idx_q;
		endcase
		case (cc.wr_addr_sel)
			WA_HI:   wr_addr_full = hi_q;
			default: wr_addr_full = idx_q;
		endcase
		case (cc.wr_data_sel)
			WD_RDATA: wdata = rdata_q;
			WD_TMP:   wdata = tmp_q;
			default:  wdata = value_q;
		endcase
	end

	assign rd_addr = rd_addr_full[AW-1:0];
	assign wr_addr = wr_addr_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (cc.wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
		if (cc.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cc.load) begin
			mode_q  <= mode_t'(in_mode);
			value_q <= in_value;
			pos_q   <= in_position;
		end
		if (cc.tmp_ld) begin
			tmp_q <= rdata_q;
		end
		if (cc.load) begin
			stat_q <= ST_OK;
		end else if (cc.set_stat) begin
			stat_q <= cc.stat;
		end
		if (cc.res_load) begin
			out_stat_q  <= stat_q;
			out_count_q <= len_ext[4:0];
			out_value_q <= (mode_q == MODE_READ && stat_q == ST_OK) ? rdata_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cc.len_inc) begin
				len_q <= len_q + LW'(1);
			end else if (cc.len_dec) begin
				len_q <= len_q - LW'(1);
			end
			if (cc.idx_ld_len) begin
				idx_q <= len_q;
			end else if (cc.idx_clr) begin
				idx_q <= '0;
			end else if (cc.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cc.idx_dec) begin
				idx_q <= idx_m1;
			end
			if (cc.hi_ld) begin
				hi_q <= len_q - LW'(1);
			end else if (cc.hi_dec) begin
				hi_q <= hi_q - LW'(1);
			end
			out_valid_q <= cc.res_load | (out_valid_q & ~res.ready);
		end
	end

	assign st.mode       = mode_q;
	assign st.full       = (len_q == LW'(CAPACITY));
	assign st.len_le1    = (len_q <= LW'(1));
	assign st.pos_ok     = (pos_ext < len_ext);
	assign st.idx_zero   = (idx_q == '0);
	assign st.idx_eq_len = (idx_q == len_q);
	assign st.idx_last   = (idx_p1_wide >= (LW + 1)'(len_q));
	assign st.idx_lt_hi  = (idx_q < hi_q);
	assign st.match      = (rdata_q == value_q);
	assign st.res_free   = ~out_valid_q | res.ready;

	assign res.valid       = out_valid_q;
	assign res.status      = out_stat_q;
	assign res.entry_count = out_count_q;
	assign res.read_value  = out_value_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length beyond capacity");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cc.wr_en |-> (wr_addr_full < LW'(CAPACITY)))
		else $error("write address beyond capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cc.res_load |-> (!out_valid_q || res.ready))
		else $error("result register overwritten while pending");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cc.len_inc || cc.len_dec) |=> (len_q != $past(len_q)))
		else $error("length failed to change");

	a_full_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cc.len_inc |-> (len_q < LW'(CAPACITY)))
		else $error("insert into a full list");

endmodule

[bench/olist_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_checker
// Watches the command and result channels of the ordered list store, keeps
// its own copy of the list, works out the result of every accepted command
// word and compares each accepted result word with the oldest one pending.
// ----------------------------------------------------------------------------
module olist_checker #(
	parameter int CAPACITY = olist_pkg::DEF_CAPACITY
) (
	input logic  clk,
	input logic  arst_n,
	olist_cmd_if cmd,
	olist_res_if res,
	output int   mismatches,
	output int   pending
);
	import olist_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [4:0]         count;
		logic signed [31:0] read_value;
	} list_result_t;

	logic signed [31:0] shadow_list [CAPACITY];
	int unsigned        shadow_len;
	list_result_t       expected_results [$];
	list_result_t       oldest;

	function automatic list_result_t apply_command(mode_t m, logic signed [31:0] v,
		logic [3:0] pos);
		list_result_t r;
		int unsigned  k;
		int unsigned  lo;
		int unsigned  hi;
		logic signed [31:0] t;
		r.status     = ST_OK;
		r.read_value = '0;
		case (m)
			MODE_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (k = shadow_len; k > 0; k--)
						shadow_list[k] = shadow_list[k - 1];
					shadow_list[0] = v;
					shadow_len++;
				end
			end
			MODE_DELETE: begin
				k = 0;
				while (k < shadow_len && shadow_list[k] != v)
					k++;
				if (k >= shadow_len) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap behind the first match
					for (; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k + 1];
					shadow_len--;
				end
			end
			MODE_REVERSE: begin
				if (shadow_len > 1) begin
					lo = 0;
					hi = shadow_len - 1;
					while (lo < hi) begin
						t               = shadow_list[lo];
						shadow_list[lo] = shadow_list[hi];
						shadow_list[hi] = t;
						lo++;
						hi--;
					end
				end
			end
			default: begin
				if (pos >= shadow_len)
					r.status = ST_RANGE;
				else
					r.read_value = shadow_list[pos];
			end
		endcase
		r.count = shadow_len[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			shadow_len = 0;
			mismatches = 0;
			pending    = 0;
		end else begin
			// result first: a word leaving now belongs to an earlier command
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, got status %0d count %0d value %0d",
						$time, res.status, res.entry_count, res.read_value);
					mismatches++;
				end else begin
					oldest = expected_results.pop_front();
					if (res.status !== oldest.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, oldest.status, res.status);
						mismatches++;
					end
					if (res.entry_count !== oldest.count) begin
						$display("%0t: entry_count mismatch, expected %0d, actual %0d",
							$time, oldest.count, res.entry_count);
						mismatches++;
					end
					if (res.read_value !== oldest.read_value) begin
						$display("%0t: read_value mismatch, expected %0d, actual %0d",
							$time, oldest.read_value, res.read_value);
						mismatches++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.push_back(apply_command(mode_t'(cmd.mode), cmd.value,
					cmd.position));
			pending = expected_results.size();
		end
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives command words into the ordered list store: a directed opening over
// the edge cases, then phases that alternately grow and drain the list with
// values from a small pool so that deletes hit, with random idling on both
// channels. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import olist_pkg::*;

	localparam int CAPACITY      = DEF_CAPACITY;
	localparam int PHASES        = 16;
	localparam int PHASE_WORDS   = 70;
	localparam int QUIET_WORDS   = 150;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	logic quiet;
	int   mismatches;
	int   pending;
	int   cycles;
	int   stall_left;

	olist_cmd_if cmd_ch ();
	olist_res_if res_ch ();

	ordered_list_store #(.CAPACITY(CAPACITY)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	olist_checker #(.CAPACITY(CAPACITY)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side back-pressure in short bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			res_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send_word(mode_t m, logic signed [31:0] v, logic [3:0] pos);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.mode     <= m;
		cmd_ch.value    <= v;
		cmd_ch.position <= pos;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	initial begin
		logic signed [31:0] pool [6];
		logic signed [31:0] v;
		int                 roll;
		int                 sent;
		int                 ins_w;
		int                 del_w;
		mode_t              m;

		cycles          = 0;
		stall_left      = 0;
		quiet           = 1'b0;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.mode     = MODE_INSERT;
		cmd_ch.value    = '0;
		cmd_ch.position = '0;
		res_ch.ready    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: read, delete and reverse all fall through
		send_word(MODE_READ, 32'sd0, 4'd15);
		send_word(MODE_DELETE, 32'sd5, 4'd0);
		send_word(MODE_REVERSE, 32'sd0, 4'd0);
		send_word(MODE_INSERT, VAL_MIN, 4'd0);
		send_word(MODE_REVERSE, 32'sd0, 4'd0);
		send_word(MODE_INSERT, VAL_MAX, 4'd0);
		send_word(MODE_INSERT, -32'sd1, 4'd0);
		send_word(MODE_REVERSE, 32'sd0, 4'd0);
		send_word(MODE_DELETE, VAL_MAX, 4'd0);
		send_word(MODE_DELETE, 32'sd7, 4'd0);
		send_word(MODE_READ, 32'sd0, 4'd1);
		// fill to capacity, then overflow
		send_word(MODE_INSERT, VAL_MAX, 4'd0);
		for (int i = 0; i < CAPACITY - 3; i++)
			send_word(MODE_INSERT, $urandom, 4'd0);
		send_word(MODE_INSERT, 32'sd0, 4'd0);
		send_word(MODE_READ, 32'sd0, 4'd15);

		sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < 6; i++)
				pool[i] = $urandom;
			pool[$urandom_range(0, 5)] = ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
			// even phases grow the list, odd ones drain it
			ins_w = (ph % 2 == 0) ? 55 : 15;
			del_w = (ph % 2 == 0) ? 15 : 55;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				quiet = (sent >= PHASES * PHASE_WORDS - QUIET_WORDS);
				roll  = $urandom_range(0, 99);
				if (roll < ins_w)
					m = MODE_INSERT;
				else if (roll < ins_w + del_w)
					m = MODE_DELETE;
				else if (roll < ins_w + del_w + 10)
					m = MODE_REVERSE;
				else
					m = MODE_READ;
				v = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 5)]
					: $urandom;
				send_word(m, v, 4'($urandom_range(0, 15)));
				sent++;
			end
		end
		cmd_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
